FILE: rtl/ftig_pkg.sv
// Shared types and constants for the five-tap image gradient unit.
// No dependencies; the other files, apart from ftig_queue, refer to names here by package scope.
package ftig_pkg;

  localparam int PIX_W       = 8;      // gray pixel and tap width
  localparam int TAP_N       = 5;      // taps per direction
  localparam int LANES       = 4;      // rows held in the line store
  localparam int ROW_W       = 11;     // row index up to MAX_HEIGHT-1
  localparam int FRAME_W     = 12;     // width of the frame size registers
  localparam int FRAME_MIN   = 3;
  localparam int MAX_HEIGHT  = 2048;
  localparam int PROD_W      = 16;     // tap times pixel
  localparam int SUM_W       = 19;     // five products summed
  localparam int MAG_W       = SUM_W - 1;
  localparam int QUO_W       = MAG_W - 2;
  localparam int SCALE_W     = 32;
  localparam int RECIP_SHIFT = 17;
  localparam logic [RECIP_SHIFT-1:0] RECIP3 = 17'd43691;  // ceil(2^17 / 3)
  localparam int GRAD_W      = 15;
  localparam int QUEUE_DEPTH = 4;

  // Configuration port
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;
  localparam int REG_IW  = 3;
  localparam logic [REG_IW-1:0] REG_TAP_0   = 3'd0;
  localparam logic [REG_IW-1:0] REG_TAP_1   = 3'd1;
  localparam logic [REG_IW-1:0] REG_TAP_2   = 3'd2;
  localparam logic [REG_IW-1:0] REG_TAP_3   = 3'd3;
  localparam logic [REG_IW-1:0] REG_TAP_4   = 3'd4;
  localparam logic [REG_IW-1:0] REG_FRAME_W = 3'd5;
  localparam logic [REG_IW-1:0] REG_FRAME_H = 3'd6;

  localparam logic [FRAME_W-1:0] FRAME_W_RESET = 12'd640;
  localparam logic [FRAME_W-1:0] FRAME_H_RESET = 12'd480;

  typedef logic signed [PIX_W-1:0]  tap_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam tap_t TAP_RESET [TAP_N] = '{8'sd1, -8'sd8, 8'sd0, 8'sd8, -8'sd1};

  // One queued operation for the back end. Masks: bit k covers offset k-2.
  typedef struct packed {
    logic              emit;
    logic              last;
    logic              wr_en;
    logic              shift;
    logic [1:0]        wr_lane;
    logic [1:0]        row_lane;
    logic [1:0]        sp_lane;
    logic [PIX_W-1:0]  pixel;
    logic [TAP_N-1:0]  vmask;
    logic [TAP_N-1:0]  hmask;
  } cmd_t;

endpackage

FILE: rtl/ftig_intf.sv
// Valid/ready channel interfaces for pixel items and gradient results.
// Depends on ftig_pkg for field widths.
interface ftig_pix_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [ftig_pkg::PIX_W-1:0] pixel;
  modport source (output valid, func, pixel, input ready);
  modport sink (input valid, func, pixel, output ready);
endinterface

interface ftig_grad_if;
  logic                               valid;
  logic                               ready;
  logic signed [ftig_pkg::GRAD_W-1:0] grad_down_rows;
  logic signed [ftig_pkg::GRAD_W-1:0] grad_across_cols;
  logic                               end_of_frame;
  modport source (output valid, grad_down_rows, grad_across_cols, end_of_frame,
                  input ready);
  modport sink (input valid, grad_down_rows, grad_across_cols, end_of_frame,
                output ready);
endinterface

FILE: rtl/ftig_front.sv
// Front end: accepts pixel and flush beats, tracks frame positions and
// turns each useful beat into a queued command. Depends on ftig_pkg, ftig_intf.
module ftig_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                               clk,
  input  logic                               rst,
  ftig_pix_if.sink                           pix_in,
  input  logic [ftig_pkg::FRAME_W-1:0]       frame_width,
  input  logic [ftig_pkg::FRAME_W-1:0]       frame_height,
  input  logic                               restart,
  input  logic                               q_ready,
  output logic                               q_push,
  output ftig_pkg::cmd_t                     cmd,
  output logic [$clog2(MAX_WIDTH)-1:0]       col,
  output logic [$clog2(MAX_WIDTH)-1:0]       sp_col_out
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = ftig_pkg::ROW_W;

  localparam logic [ftig_pkg::FRAME_W-1:0] FRAME_W_MIN =
    ftig_pkg::FRAME_W'(ftig_pkg::FRAME_MIN);

  logic [WW-1:0]                  eff_w;
  logic [ftig_pkg::FRAME_W-1:0]   eff_h;
  logic [CW-1:0]                  w_m1, w_m2;
  logic [RW-1:0]                  h_m1;

  logic [RW:0]   in_row;
  logic [CW-1:0] in_col;
  logic [RW-1:0] out_row;
  logic [CW-1:0] out_col;
  logic [1:0]    sp_lane;
  logic [CW-1:0] sp_col;

  logic is_pix, draining, take, act_pix, act_flush;
  logic emit_pix, shift_pix, frame_end;

  always_comb begin
    priority if (frame_width < FRAME_W_MIN) begin
      eff_w = WW'(ftig_pkg::FRAME_MIN);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width);
    end
    priority if (frame_height < FRAME_W_MIN) begin
      eff_h = ftig_pkg::FRAME_W'(ftig_pkg::FRAME_MIN);
    end else if (int'(frame_height) > ftig_pkg::MAX_HEIGHT) begin
      eff_h = ftig_pkg::FRAME_W'(ftig_pkg::MAX_HEIGHT);
    end else begin
      eff_h = frame_height;
    end
  end

  assign w_m1 = CW'(eff_w - 1'b1);
  assign w_m2 = w_m1 - 1'b1;
  assign h_m1 = RW'(eff_h - 1'b1);

  assign is_pix    = !pix_in.func;
  assign draining  = in_row > {1'b0, h_m1};
  assign take      = pix_in.valid && q_ready;
  assign act_pix   = take && is_pix && !draining;
  assign act_flush = take && !is_pix && draining;
  assign emit_pix  = in_row >= (RW+1)'(2);
  assign shift_pix = emit_pix || ((in_row == (RW+1)'(1)) && (in_col >= w_m2));
  assign frame_end = (out_row == h_m1) && (out_col == w_m1);

  assign pix_in.ready = q_ready;
  assign q_push       = act_pix || act_flush;
  assign col          = is_pix ? in_col : out_col;
  assign sp_col_out   = sp_col;

  always_comb begin
    cmd.emit     = is_pix ? emit_pix : 1'b1;
    cmd.last     = !is_pix && frame_end;
    cmd.wr_en    = is_pix;
    cmd.shift    = is_pix ? shift_pix : 1'b1;
    cmd.wr_lane  = in_row[1:0];
    cmd.row_lane = out_row[1:0];
    cmd.sp_lane  = sp_lane;
    cmd.pixel    = pix_in.pixel;
    // rows below the frame bottom and above the top read as zero
    cmd.vmask    = {is_pix, out_row != h_m1, 1'b1,
                    out_row >= RW'(1), out_row >= RW'(2)};
    cmd.hmask    = {col < w_m2, col < w_m1, 1'b1,
                    col >= CW'(1), col >= CW'(2)};
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
      sp_lane <= '0;
      sp_col  <= '0;
    end else if (act_pix) begin
      if (in_col == w_m1) begin
        in_col <= '0;
        in_row <= in_row + 1'b1;
      end else begin
        in_col <= in_col + 1'b1;
      end
      if (emit_pix) begin
        if (out_col == w_m1) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
      if (shift_pix) begin
        if (sp_col == w_m1) begin
          sp_col  <= '0;
          sp_lane <= sp_lane + 1'b1;
        end else begin
          sp_col <= sp_col + 1'b1;
        end
      end
    end else if (act_flush) begin
      if (frame_end) begin
        in_row  <= '0;
        in_col  <= '0;
        out_row <= '0;
        out_col <= '0;
        sp_lane <= '0;
        sp_col  <= '0;
      end else begin
        if (out_col == w_m1) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
        if (sp_col == w_m1) begin
          sp_col  <= '0;
          sp_lane <= sp_lane + 1'b1;
        end else begin
          sp_col <= sp_col + 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/ftig_queue.sv
// Small command queue between the front and back ends.
// Depends on nothing outside this file.
module ftig_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [NW-1:0]    cnt;
  logic             do_push, do_pop;

  assign push_ready = cnt != NW'(DEPTH);
  assign pop_valid  = cnt != '0;
  assign pop_data   = slots[rptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

FILE: rtl/ftig_back.sv
// Back end: line store, raster look-ahead window, tap products, sums,
// divide by twelve and the result register. Depends on ftig_pkg, ftig_intf.
module ftig_back #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  ftig_pkg::cmd_t                cmd,
  input  logic [$clog2(MAX_WIDTH)-1:0]  col,
  input  logic [$clog2(MAX_WIDTH)-1:0]  sp_col,
  input  ftig_pkg::tap_t                taps [ftig_pkg::TAP_N],
  ftig_grad_if.source                   grad_out
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int N  = ftig_pkg::TAP_N;
  localparam int PW = ftig_pkg::PIX_W;

  logic adv;

  // stage 1: line store read
  logic           v1;
  ftig_pkg::cmd_t c1;
  logic [PW-1:0]  rd_a [ftig_pkg::LANES];
  logic [PW-1:0]  rd_b [ftig_pkg::LANES];
  logic [PW-1:0]  win  [4];          // raster stream at offsets +1, 0, -1, -2

  // stage 2: products
  logic            v2, last2;
  ftig_pkg::prod_t pv [N];
  ftig_pkg::prod_t ph [N];

  // stage 3: sums
  logic            v3, last3;
  ftig_pkg::sum_t  sd, sa;

  // stage 4: scaled magnitudes
  logic                              v4, last4, neg_d, neg_a;
  logic [ftig_pkg::SCALE_W-1:0]      sc_d, sc_a;

  // result register
  logic                              out_valid, out_eof;
  logic signed [ftig_pkg::GRAD_W-1:0] out_d, out_a;

  assign adv   = !out_valid || grad_out.ready;
  assign q_pop = adv && q_valid;

  for (genvar l = 0; l < ftig_pkg::LANES; l++) begin : g_lane
    logic [PW-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (q_pop && cmd.wr_en && (cmd.wr_lane == 2'(l))) begin
        mem[col] <= cmd.pixel;
      end
      if (adv) begin
        rd_a[l] <= mem[col];
        rd_b[l] <= mem[sp_col];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= q_valid;
      v2        <= v1 && c1.emit;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // stage 1 selection and masking
  logic [PW-1:0]   vsrc [N];
  logic [PW-1:0]   hsrc [N];
  logic [PW-1:0]   vp   [N];
  logic [PW-1:0]   hp   [N];
  ftig_pkg::prod_t pv_c [N];
  ftig_pkg::prod_t ph_c [N];
  logic [PW-1:0]   next_b;

  always_comb begin
    next_b  = rd_b[c1.sp_lane];
    vsrc[0] = rd_a[2'(c1.row_lane + 2'd2)];
    vsrc[1] = rd_a[2'(c1.row_lane + 2'd3)];
    vsrc[2] = rd_a[c1.row_lane];
    vsrc[3] = rd_a[2'(c1.row_lane + 2'd1)];
    vsrc[4] = c1.pixel;
    hsrc[0] = win[3];
    hsrc[1] = win[2];
    hsrc[2] = rd_a[c1.row_lane];
    hsrc[3] = win[0];
    hsrc[4] = next_b;
    for (int k = 0; k < N; k++) begin
      vp[k]   = c1.vmask[k] ? vsrc[k] : '0;
      hp[k]   = c1.hmask[k] ? hsrc[k] : '0;
      pv_c[k] = ftig_pkg::PROD_W'(taps[k]) * ftig_pkg::PROD_W'($signed({1'b0, vp[k]}));
      ph_c[k] = ftig_pkg::PROD_W'(taps[k]) * ftig_pkg::PROD_W'($signed({1'b0, hp[k]}));
    end
  end

  // advance the raster window on every beat that fetched a new pixel
  always_ff @(posedge clk) begin
    if (adv && v1 && c1.shift) begin
      win[0] <= next_b;
      win[1] <= win[0];
      win[2] <= win[1];
      win[3] <= win[2];
    end
  end

  ftig_pkg::sum_t                sd_c, sa_c;
  logic [ftig_pkg::MAG_W-1:0]    mag_d, mag_a;
  logic [ftig_pkg::QUO_W-1:0]    quo_d, quo_a;
  logic [ftig_pkg::GRAD_W-1:0]   q_d, q_a;

  always_comb begin
    sd_c = '0;
    sa_c = '0;
    for (int k = 0; k < N; k++) begin
      sd_c = sd_c + ftig_pkg::SUM_W'(pv[k]);
      sa_c = sa_c + ftig_pkg::SUM_W'(ph[k]);
    end
    // |x| / 12 as (|x| >> 2) / 3, sign restored after
    mag_d = sd[ftig_pkg::SUM_W-1] ? ftig_pkg::MAG_W'(-sd) : ftig_pkg::MAG_W'(sd);
    mag_a = sa[ftig_pkg::SUM_W-1] ? ftig_pkg::MAG_W'(-sa) : ftig_pkg::MAG_W'(sa);
    quo_d = mag_d[ftig_pkg::MAG_W-1:2];
    quo_a = mag_a[ftig_pkg::MAG_W-1:2];
    q_d   = sc_d[ftig_pkg::RECIP_SHIFT +: ftig_pkg::GRAD_W];
    q_a   = sc_a[ftig_pkg::RECIP_SHIFT +: ftig_pkg::GRAD_W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1    <= cmd;
      last2 <= c1.last;
      pv    <= pv_c;
      ph    <= ph_c;
      last3 <= last2;
      sd    <= sd_c;
      sa    <= sa_c;
      last4 <= last3;
      neg_d <= sd[ftig_pkg::SUM_W-1];
      neg_a <= sa[ftig_pkg::SUM_W-1];
      sc_d  <= ftig_pkg::SCALE_W'(quo_d) * ftig_pkg::SCALE_W'(ftig_pkg::RECIP3);
      sc_a  <= ftig_pkg::SCALE_W'(quo_a) * ftig_pkg::SCALE_W'(ftig_pkg::RECIP3);
      out_eof <= last4;
      out_d   <= neg_d ? -$signed(q_d) : $signed(q_d);
      out_a   <= neg_a ? -$signed(q_a) : $signed(q_a);
    end
  end

  assign grad_out.valid            = out_valid;
  assign grad_out.grad_down_rows   = out_d;
  assign grad_out.grad_across_cols = out_a;
  assign grad_out.end_of_frame     = out_eof;

endmodule

FILE: rtl/five_tap_image_gradient_unit.sv
// Five-tap image gradient unit, top level: configuration registers,
// front end, command queue and back end. Depends on ftig_pkg, ftig_intf.
//
//   channel    kind        beat carries
//   pix_in     valid/ready func, pixel
//   grad_out   valid/ready grad_down_rows, grad_across_cols, end_of_frame
//   apb        psel/pen    tap_0..tap_4, frame_width, frame_height
//
// One beat per clock on pix_in while the queue has room; the back end is a
// five-register pipeline (line store read, products, sums, divide-by-twelve
// multiply, result) fed from a four-entry command queue. A stalled grad_out
// freezes the back end; pix_in keeps flowing until the queue fills. Reset
// clears control state only; the line store is not cleared and needs no
// clearing pass.
module five_tap_image_gradient_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                            clk,
  input  logic                            rst,
  ftig_pix_if.sink                        pix_in,
  ftig_grad_if.source                     grad_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ftig_pkg::APB_AW-1:0]     paddr,
  input  logic [ftig_pkg::APB_DW-1:0]     pwdata,
  output logic [ftig_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = $bits(ftig_pkg::cmd_t) + 2 * CW;

  ftig_pkg::tap_t                 taps [ftig_pkg::TAP_N];
  logic [ftig_pkg::FRAME_W-1:0]   frame_width, frame_height;
  logic [ftig_pkg::REG_IW-1:0]    reg_idx;
  logic                           cfg_wr, restart;

  logic           q_ready, q_push, q_valid, q_pop;
  ftig_pkg::cmd_t f_cmd, b_cmd;
  logic [CW-1:0]  f_col, f_sp_col, b_col, b_sp_col;
  logic [QW-1:0]  q_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ftig_pkg::APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign restart = cfg_wr &&
                   (reg_idx == ftig_pkg::REG_FRAME_W || reg_idx == ftig_pkg::REG_FRAME_H);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ftig_pkg::TAP_N; k++) begin
        taps[k] <= ftig_pkg::TAP_RESET[k];
      end
      frame_width  <= ftig_pkg::FRAME_W_RESET;
      frame_height <= ftig_pkg::FRAME_H_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ftig_pkg::REG_TAP_0:   taps[0] <= pwdata[ftig_pkg::PIX_W-1:0];
        ftig_pkg::REG_TAP_1:   taps[1] <= pwdata[ftig_pkg::PIX_W-1:0];
        ftig_pkg::REG_TAP_2:   taps[2] <= pwdata[ftig_pkg::PIX_W-1:0];
        ftig_pkg::REG_TAP_3:   taps[3] <= pwdata[ftig_pkg::PIX_W-1:0];
        ftig_pkg::REG_TAP_4:   taps[4] <= pwdata[ftig_pkg::PIX_W-1:0];
        ftig_pkg::REG_FRAME_W: frame_width  <= pwdata[ftig_pkg::FRAME_W-1:0];
        ftig_pkg::REG_FRAME_H: frame_height <= pwdata[ftig_pkg::FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ftig_pkg::REG_TAP_0:   prdata = ftig_pkg::APB_DW'(taps[0]);
      ftig_pkg::REG_TAP_1:   prdata = ftig_pkg::APB_DW'(taps[1]);
      ftig_pkg::REG_TAP_2:   prdata = ftig_pkg::APB_DW'(taps[2]);
      ftig_pkg::REG_TAP_3:   prdata = ftig_pkg::APB_DW'(taps[3]);
      ftig_pkg::REG_TAP_4:   prdata = ftig_pkg::APB_DW'(taps[4]);
      ftig_pkg::REG_FRAME_W: prdata = ftig_pkg::APB_DW'(frame_width);
      ftig_pkg::REG_FRAME_H: prdata = ftig_pkg::APB_DW'(frame_height);
      default:               prdata = '0;
    endcase
  end

  ftig_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .pix_in       (pix_in),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .restart      (restart),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .cmd          (f_cmd),
    .col          (f_col),
    .sp_col_out   (f_sp_col)
  );

  ftig_queue #(.WIDTH(QW), .DEPTH(ftig_pkg::QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  ({f_cmd, f_col, f_sp_col}),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_out)
  );

  assign {b_cmd, b_col, b_sp_col} = q_out;

  ftig_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .cmd      (b_cmd),
    .col      (b_col),
    .sp_col   (b_sp_col),
    .taps     (taps),
    .grad_out (grad_out)
  );

endmodule
